// ===== sv/rtdps_pkg.sv =====
// ----------------------------------------------------------------------------
// rtdps_pkg: shared types and codes of the RTD converter poll sequencer
// Per-sensor and global state records, result word layout, bus request codes
// and sensor phase codes.
// ----------------------------------------------------------------------------
package rtdps_pkg;

	localparam int SENSORS_DEF = 2;

	// bus request codes
	localparam logic [2:0] REQ_NONE      = 3'd0;
	localparam logic [2:0] REQ_RD_CFG    = 3'd1;
	localparam logic [2:0] REQ_WR_CFG    = 3'd2;
	localparam logic [2:0] REQ_WR_THR    = 3'd3;
	localparam logic [2:0] REQ_RD_MEAS   = 3'd4;
	localparam logic [2:0] REQ_RD_FAULT  = 3'd5;
	localparam logic [2:0] REQ_CLR_FAULT = 3'd6;

	// sensor phases
	localparam logic [2:0] PH_INIT      = 3'd0;
	localparam logic [2:0] PH_INIT_CONT = 3'd1;
	localparam logic [2:0] PH_INIT_DONE = 3'd2;
	localparam logic [2:0] PH_EOC       = 3'd3;
	localparam logic [2:0] PH_EOC_CHK   = 3'd4;
	localparam logic [2:0] PH_ERR_READ  = 3'd5;
	localparam logic [2:0] PH_ERR_CHK   = 3'd6;

	localparam logic [1:0] STEP_FIRST  = 2'd1;
	localparam logic [1:0] STEP_SECOND = 2'd2;

	localparam logic       STATUS_SHORT     = 1'b0;
	localparam logic       STATUS_OPEN      = 1'b1;
	localparam logic [7:0] FAULT_SHORT_MASK = 8'h44;
	localparam int         FAULT_OPEN_BIT   = 7;
	localparam logic [7:0] CLEAR_FAULT_CMD  = 8'hC2;
	localparam logic [2:0] ZERO_CNT_MAX     = 3'd7;
	localparam logic [2:0] ZERO_CNT_REINIT  = 3'd5;

	// register indexes on the configuration port
	localparam logic [1:0] REG_SENSOR_EN  = 2'd0;
	localparam logic [1:0] REG_CONFIG     = 2'd1;
	localparam logic [1:0] REG_HIGH_THR   = 2'd2;
	localparam logic [1:0] REG_LOW_THR    = 2'd3;

	localparam logic [7:0]  CONFIG_RST   = 8'd192;
	localparam logic [15:0] HIGH_THR_RST = 16'd22692;
	localparam logic [15:0] LOW_THR_RST  = 16'd2458;

	typedef struct packed {
		logic [2:0]  phase;
		logic [1:0]  step;
		logic        done;
		logic [23:0] meas;   // config byte, measurement high, measurement low
	} sens_t;

	typedef struct packed {
		logic [7:0] fault;
		logic [2:0] last_req;
		logic [2:0] zero_cnt;
		logic       reinit;
	} glob_t;

	typedef struct packed {
		logic        reinit_request;
		logic        status_code;
		logic        status_sensor;
		logic        status_valid;
		logic [14:0] sample_value;
		logic        sample_sensor;
		logic        sample_valid;
		logic [31:0] tx_payload;
		logic        request_sensor;
		logic [2:0]  bus_request;
	} result_t;

	localparam int RESULT_W = $bits(result_t);
	localparam int TDATA_W  = ((RESULT_W + 7) / 8) * 8;

endpackage

// ===== sv/rtdps_step.sv =====
// ----------------------------------------------------------------------------
// rtdps_step: next-state and result logic for one event
// Takes the current sensor's record and the global record, applies a poll
// tick or a transfer-done event and forms the result word.
// ----------------------------------------------------------------------------
module rtdps_step (
	input  logic                command,
	input  logic [7:0]          rx_byte1,
	input  logic [7:0]          rx_byte2,
	input  logic [7:0]          rx_byte3,
	input  logic                cur,
	input  logic                second_en,
	input  logic [7:0]          config_byte,
	input  logic [15:0]         high_threshold,
	input  logic [15:0]         low_threshold,
	input  rtdps_pkg::sens_t    sens_in,
	input  rtdps_pkg::glob_t    glob_in,
	output rtdps_pkg::sens_t    sens_out,
	output rtdps_pkg::glob_t    glob_out,
	output logic                cur_out,
	output rtdps_pkg::result_t  res
);
	import rtdps_pkg::*;

	logic        nxt;
	logic [1:0]  step_inc;
	logic [2:0]  req;
	logic [31:0] payload;
	logic [14:0] val;
	logic [2:0]  zc_inc;

	assign nxt      = (cur == 1'b0) && second_en;
	assign step_inc = sens_in.step + 2'd1;
	assign val      = sens_in.meas[15:1];
	assign zc_inc   = glob_in.zero_cnt + 3'd1;

	always_comb begin
		sens_out = sens_in;
		glob_out = glob_in;
		cur_out  = cur;
		res      = '0;
		req      = REQ_NONE;
		payload  = '0;
		if (command) begin
			case (glob_in.last_req)
				REQ_RD_CFG: sens_out.meas[23:16] = rx_byte1;
				REQ_RD_MEAS: sens_out.meas = {rx_byte1, rx_byte2, rx_byte3};
				REQ_RD_FAULT, REQ_CLR_FAULT: glob_out.fault = rx_byte1;
				default: ;
			endcase
			sens_out.done     = 1'b1;
			glob_out.last_req = REQ_NONE;
		end else if (sens_in.done || sens_in.phase > PH_ERR_CHK) begin
			case (sens_in.phase)
				PH_INIT: begin
					sens_out.done  = 1'b0;
					sens_out.phase = PH_INIT_CONT;
					req            = REQ_RD_CFG;
				end
				PH_INIT_CONT: begin
					sens_out.done  = 1'b0;
					sens_out.phase = PH_INIT_DONE;
					sens_out.step  = step_inc;
					if (step_inc == STEP_FIRST) begin
						req     = REQ_WR_CFG;
						payload = {24'd0, config_byte};
					end else if (step_inc == STEP_SECOND) begin
						req     = REQ_WR_THR;
						payload = {high_threshold, low_threshold};
					end
				end
				PH_INIT_DONE: begin
					sens_out.phase = (sens_in.step == STEP_SECOND) ? PH_EOC : PH_INIT;
					cur_out        = nxt;
				end
				PH_EOC: begin
					sens_out.done  = 1'b0;
					sens_out.phase = PH_EOC_CHK;
					req            = REQ_RD_MEAS;
				end
				PH_EOC_CHK: begin
					sens_out.phase    = PH_EOC;
					res.sample_valid  = 1'b1;
					res.sample_sensor = cur;
					res.sample_value  = val;
					if (val == '0) begin
						if (sens_in.meas[23:16] == 8'd0) begin
							if (glob_in.zero_cnt < ZERO_CNT_MAX) begin
								glob_out.zero_cnt = zc_inc;
								if (zc_inc == ZERO_CNT_REINIT)
									glob_out.reinit = 1'b1;
							end
						end else begin
							glob_out.zero_cnt = '0;
						end
					end
					// fault flag rides in bit 0 of the low byte
					if (sens_in.meas[0]) begin
						sens_out.phase = PH_ERR_READ;
						sens_out.step  = '0;
					end else begin
						cur_out = nxt;
					end
				end
				PH_ERR_READ: begin
					sens_out.done  = 1'b0;
					sens_out.phase = PH_ERR_CHK;
					sens_out.step  = step_inc;
					if (step_inc == STEP_FIRST) begin
						req = REQ_RD_FAULT;
					end else if (step_inc == STEP_SECOND) begin
						req     = REQ_CLR_FAULT;
						payload = {24'd0, CLEAR_FAULT_CMD};
					end
				end
				PH_ERR_CHK: begin
					sens_out.phase = PH_ERR_READ;
					if (sens_in.step == STEP_FIRST) begin
						if ((glob_in.fault & FAULT_SHORT_MASK) != 8'd0) begin
							res.status_valid  = 1'b1;
							res.status_sensor = cur;
							res.status_code   = STATUS_SHORT;
						end else if (glob_in.fault[FAULT_OPEN_BIT]) begin
							res.status_valid  = 1'b1;
							res.status_sensor = cur;
							res.status_code   = STATUS_OPEN;
						end
					end else if (sens_in.step == STEP_SECOND) begin
						sens_out.phase = PH_EOC;
						cur_out        = nxt;
					end
				end
				default: sens_out.phase = PH_INIT;
			endcase
			if (req != REQ_NONE) begin
				glob_out.last_req  = req;
				res.bus_request    = req;
				res.request_sensor = cur;
				res.tx_payload     = payload;
			end
		end
		res.reinit_request = glob_out.reinit;
	end

endmodule

// ===== sv/rtd_converter_poll_sequencer.sv =====
// ----------------------------------------------------------------------------
// rtd_converter_poll_sequencer: poll sequencer for one or two RTD converters
// Input: s_tuser = command (0 poll tick, 1 transfer done), s_tdata = received
// bytes. Output: one result word per event (bus request, sample, fault status).
// Config: APB registers sensor enable, config byte, high and low thresholds.
// ----------------------------------------------------------------------------
// Each accepted event yields exactly one result transfer. The event is held in
// an input register, where the step logic updates the state of the current
// sensor and forms the result, which lands in the output register. Throughput
// is one event per cycle unless the receiver stalls; then the output register
// holds its word and the input register holds the next event. s_tready drops
// once both are full and rises in the same cycle that m_tready takes the
// waiting result.
// Reset puts every sensor in the init phase with transfer done set, selects
// sensor zero, clears the zero counter and reinit flag, loads register reset
// values. Users write registers only while the block is idle (unchecked).
// ----------------------------------------------------------------------------
module rtd_converter_poll_sequencer #(
	parameter int SENSORS = rtdps_pkg::SENSORS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [23:0]                   s_tdata,  // rx_byte1, rx_byte2, rx_byte3
	input  logic                          s_tuser,  // command
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// bus_request, request_sensor, tx_payload, sample_valid, sample_sensor,
	// sample_value, status_valid, status_sensor, status_code, reinit_request
	output logic [rtdps_pkg::TDATA_W-1:0] m_tdata,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [3:0]                    paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);
	import rtdps_pkg::*;

	logic        sensor_en_q;
	logic [7:0]  config_q;
	logic [15:0] high_thr_q;
	logic [15:0] low_thr_q;

	logic [2:0]  phase_q [SENSORS];
	logic [1:0]  step_q  [SENSORS];
	logic        done_q  [SENSORS];
	logic [23:0] meas_q  [SENSORS];
	logic        cur_q;
	glob_t       glob_q;

	logic        valid_s1;
	logic        cmd_s1;
	logic [23:0] data_s1;

	logic        out_valid_q;
	result_t     out_q;

	logic        advance;
	logic        cfg_wr;
	logic        second_en;
	sens_t       sens_cur;
	sens_t       sens_nxt;
	glob_t       glob_nxt;
	logic        cur_nxt;
	result_t     res;

	assign pready    = 1'b1;
	assign cfg_wr    = psel && penable && pwrite && pready;
	assign second_en = (SENSORS > 1) && sensor_en_q;

	always_comb begin
		case (paddr[3:2])
			REG_SENSOR_EN: prdata = {31'd0, sensor_en_q};
			REG_CONFIG:    prdata = {24'd0, config_q};
			REG_HIGH_THR:  prdata = {16'd0, high_thr_q};
			REG_LOW_THR:   prdata = {16'd0, low_thr_q};
			default:       prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sensor_en_q <= 1'b0;
			config_q    <= CONFIG_RST;
			high_thr_q  <= HIGH_THR_RST;
			low_thr_q   <= LOW_THR_RST;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_SENSOR_EN: sensor_en_q <= pwdata[0];
				REG_CONFIG:    config_q    <= pwdata[7:0];
				REG_HIGH_THR:  high_thr_q  <= pwdata[15:0];
				REG_LOW_THR:   low_thr_q   <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// advance the held event when the output register is free or being taken
	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			cmd_s1  <= s_tuser;
			data_s1 <= s_tdata;
		end
	end

	assign sens_cur = '{phase: phase_q[cur_q], step: step_q[cur_q],
	                    done: done_q[cur_q], meas: meas_q[cur_q]};

	rtdps_step u_step (
		.command        (cmd_s1),
		.rx_byte1       (data_s1[7:0]),
		.rx_byte2       (data_s1[15:8]),
		.rx_byte3       (data_s1[23:16]),
		.cur            (cur_q),
		.second_en      (second_en),
		.config_byte    (config_q),
		.high_threshold (high_thr_q),
		.low_threshold  (low_thr_q),
		.sens_in        (sens_cur),
		.glob_in        (glob_q),
		.sens_out       (sens_nxt),
		.glob_out       (glob_nxt),
		.cur_out        (cur_nxt),
		.res            (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SENSORS; i++) begin
				phase_q[i] <= PH_INIT;
				step_q[i]  <= '0;
				done_q[i]  <= 1'b1;
				meas_q[i]  <= '0;
			end
			cur_q  <= 1'b0;
			glob_q <= '{fault: 8'd0, last_req: REQ_NONE, zero_cnt: 3'd0, reinit: 1'b0};
		end else if (advance) begin
			for (int i = 0; i < SENSORS; i++) begin
				if (cur_q == 1'(i)) begin
					phase_q[i] <= sens_nxt.phase;
					step_q[i]  <= sens_nxt.step;
					done_q[i]  <= sens_nxt.done;
					meas_q[i]  <= sens_nxt.meas;
				end
			end
			cur_q  <= cur_nxt;
			glob_q <= glob_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance)
			out_q <= res;
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(TDATA_W - RESULT_W){1'b0}}, out_q};

	// a result carries a sample or a fault status, never both
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(out_q.sample_valid && out_q.status_valid))
		else $error("sample and status in one result");

	// reinit request stays set until reset
	assert property (@(posedge clk) disable iff (!arst_n)
		glob_q.reinit |=> glob_q.reinit)
		else $error("reinit flag dropped");

	// a stalled event stays in the input register
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> (valid_s1 && $stable(data_s1) && $stable(cmd_s1)))
		else $error("held event lost");

	// a request is only issued on a poll tick
	assert property (@(posedge clk) disable iff (!arst_n)
		(advance && res.bus_request != REQ_NONE) |-> !cmd_s1)
		else $error("request on transfer done");

endmodule
